// ===== hw/rtl/length_prefixed_packet_reassembly_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LENGTH_PREFIXED_PACKET_REASSEMBLY_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_REASSEMBLY_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define LPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpr check failed");

// Next-cycle implication, off while reset is held.
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpr check failed");

// Next-cycle implication that also holds across reset.
`define LPR_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lpr check failed");

`endif

// ===== hw/rtl/lpr_pkg.sv =====
package lpr_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int MAX_PACKET   = 64;
  localparam int CH_W         = 3;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = $clog2(MAX_PACKET + 1);
  localparam int IDX_W        = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
  localparam int STORE_DEPTH  = NUM_CHANNELS * MAX_PACKET;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_channel;
    logic [BYTE_W-1:0] out_byte;
    logic              first_byte;
    logic              last_byte;
    logic              length_error;
  } out_item_t;

  // Work passed from the front to the back.
  typedef enum logic [1:0] {
    K_WRITE = 2'd0,
    K_ERROR = 2'd1,
    K_EMIT  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CH_W-1:0]   channel;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  len;
  } op_t;

  function automatic logic [ADDR_W-1:0] store_addr(logic [CH_W-1:0] ch,
                                                   logic [IDX_W-1:0] idx);
    return ADDR_W'(ch) * ADDR_W'(MAX_PACKET) + ADDR_W'(idx);
  endfunction

endpackage

// ===== hw/rtl/lpr_front.sv =====
module lpr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lpr_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output lpr_pkg::op_t     q_op
);

  logic [lpr_pkg::CNT_W-1:0] fill_r [lpr_pkg::NUM_CHANNELS];
  logic [lpr_pkg::CNT_W-1:0] len_r  [lpr_pkg::NUM_CHANNELS];

  logic                      accept;
  logic                      in_range;
  logic [lpr_pkg::CNT_W-1:0] fill;
  logic [lpr_pkg::CNT_W-1:0] len;
  logic [lpr_pkg::CNT_W-1:0] fill_inc;
  logic                      bad_len;
  logic                      broken;
  logic                      upd;
  logic [lpr_pkg::CNT_W-1:0] fill_nxt;
  logic [lpr_pkg::CNT_W-1:0] len_nxt;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign in_range = int'(in_data.channel) < lpr_pkg::NUM_CHANNELS;

  always_comb begin
    fill     = fill_r[in_data.channel];
    len      = len_r[in_data.channel];
    fill_inc = fill + lpr_pkg::CNT_W'(1);
    bad_len  = 1'b0;
    if (fill == '0) begin
      bad_len = (in_data.rx_byte == '0) ||
                (in_data.rx_byte > lpr_pkg::BYTE_W'(lpr_pkg::MAX_PACKET));
      len     = in_data.rx_byte[lpr_pkg::CNT_W-1:0];
    end
    // Inconsistent per-channel state: reset it and drop the byte.
    broken = (len == '0) || (len > lpr_pkg::CNT_W'(lpr_pkg::MAX_PACKET)) || (fill >= len);

    upd        = 1'b0;
    fill_nxt   = '0;
    len_nxt    = '0;
    q_push     = 1'b0;
    q_op.kind  = lpr_pkg::K_WRITE;
    q_op.channel = in_data.channel;
    q_op.idx   = fill[lpr_pkg::IDX_W-1:0];
    q_op.data  = in_data.rx_byte;
    q_op.len   = len;

    if (accept && in_range) begin
      if (bad_len) begin
        q_push    = 1'b1;
        q_op.kind = lpr_pkg::K_ERROR;
      end else if (broken) begin
        upd = 1'b1;
      end else if (fill_inc < len) begin
        upd       = 1'b1;
        fill_nxt  = fill_inc;
        len_nxt   = len;
        q_push    = 1'b1;
        q_op.kind = lpr_pkg::K_WRITE;
      end else begin
        upd       = 1'b1;
        q_push    = 1'b1;
        q_op.kind = lpr_pkg::K_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lpr_pkg::NUM_CHANNELS; i++) begin
        fill_r[i] <= '0;
        len_r[i]  <= '0;
      end
    end else if (upd) begin
      fill_r[in_data.channel] <= fill_nxt;
      len_r[in_data.channel]  <= len_nxt;
    end
  end

endmodule

// ===== hw/rtl/lpr_queue.sv =====
module lpr_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  lpr_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output lpr_pkg::op_t head,
  output logic         empty
);

  lpr_pkg::op_t               slot_r [lpr_pkg::QUEUE_DEPTH];
  logic [lpr_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [lpr_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [lpr_pkg::QCNT_W-1:0] count_r;

  assign full  = count_r == lpr_pkg::QCNT_W'(lpr_pkg::QUEUE_DEPTH);
  assign empty = count_r == '0;
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == lpr_pkg::QUEUE_DEPTH - 1) ? '0 :
                    wr_ptr_r + lpr_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == lpr_pkg::QUEUE_DEPTH - 1) ? '0 :
                    rd_ptr_r + lpr_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + lpr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - lpr_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/lpr_back.sv =====
module lpr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  lpr_pkg::op_t      q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output lpr_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  logic [lpr_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic [lpr_pkg::CNT_W-1:0]  len_r, len_nxt;
  logic [lpr_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                       rd_pending_r;
  logic [lpr_pkg::BYTE_W-1:0] rdata_r;
  logic                       rd_first_r;
  logic                       rd_last_r;
  logic                       out_valid_r;
  lpr_pkg::out_item_t         out_data_r;

  logic [lpr_pkg::BYTE_W-1:0] mem [lpr_pkg::STORE_DEPTH];

  logic                      out_free;
  logic                      load_rd;
  logic                      issue;
  logic                      mem_we;
  logic                      err_load;
  logic [lpr_pkg::CNT_W-1:0] idx_inc;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign load_rd   = rd_pending_r && out_free;
  assign idx_inc   = idx_r + lpr_pkg::CNT_W'(1);

  always_comb begin
    q_pop     = 1'b0;
    issue     = 1'b0;
    state_nxt = state_r;
    ch_nxt    = ch_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        // Hold off until the last read byte has left for the output register.
        if (!q_empty && !rd_pending_r &&
            (q_head.kind != lpr_pkg::K_ERROR || out_free)) begin
          q_pop = 1'b1;
          if (q_head.kind == lpr_pkg::K_EMIT) begin
            state_nxt = S_READ;
            ch_nxt    = q_head.channel;
            len_nxt   = q_head.len;
            idx_nxt   = '0;
          end
        end
      end
      S_READ: begin
        issue = !rd_pending_r || load_rd;
        if (issue) begin
          idx_nxt = idx_inc;
          if (idx_inc == len_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign mem_we   = q_pop && (q_head.kind != lpr_pkg::K_ERROR);
  assign err_load = q_pop && (q_head.kind == lpr_pkg::K_ERROR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[lpr_pkg::store_addr(q_head.channel, q_head.idx)] <= q_head.data;
    end
    if (issue) begin
      rdata_r <= mem[lpr_pkg::store_addr(ch_r, idx_r[lpr_pkg::IDX_W-1:0])];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_first_r <= idx_r == '0;
      rd_last_r  <= idx_inc == len_r;
    end
    if (load_rd) begin
      out_data_r.out_channel  <= ch_r;
      out_data_r.out_byte     <= rdata_r;
      out_data_r.first_byte   <= rd_first_r;
      out_data_r.last_byte    <= rd_last_r;
      out_data_r.length_error <= 1'b0;
    end else if (err_load) begin
      out_data_r.out_channel  <= q_head.channel;
      out_data_r.out_byte     <= q_head.data;
      out_data_r.first_byte   <= 1'b0;
      out_data_r.last_byte    <= 1'b1;
      out_data_r.length_error <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ch_r         <= '0;
      len_r        <= '0;
      idx_r        <= '0;
      rd_pending_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      if (issue) begin
        rd_pending_r <= 1'b1;
      end else if (load_rd) begin
        rd_pending_r <= 1'b0;
      end
      if (load_rd || err_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/length_prefixed_packet_reassembly_core.sv =====
// Channel  Direction  Ports                          Carries
// in       input      in_valid, in_stall, in_data    channel, rx_byte
// out      output     out_valid, out_stall, out_data one packet byte or an error mark
//
// Every accepted byte of a well-formed packet costs one store write in the back end; a completed
// packet then streams out at one byte per cycle from the store's registered read port while
// out_stall is low.
// A four-entry queue parts the front from the back; in_stall rises only when it is full.
// Reset (rst_n low, synchronous) clears fill counts, lengths, queue and output valid;
// the packet store needs no clearing, as only bytes written for a packet are read back.
module length_prefixed_packet_reassembly_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lpr_pkg::out_item_t out_data
);

  logic         q_full;
  logic         q_push;
  lpr_pkg::op_t q_op;
  logic         q_pop;
  lpr_pkg::op_t q_head;
  logic         q_empty;

  lpr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (q_op)
  );

  lpr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  lpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/lpr_checker.sv =====
`include "length_prefixed_packet_reassembly_core_defines.svh"

module lpr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input lpr_pkg::out_item_t out_data
);

  logic err_shape;
  logic pkt_err_clear;

  assign err_shape     = out_data.last_byte && !out_data.first_byte;
  assign pkt_err_clear = !out_data.length_error;

  // A stalled transaction stays put.
  `LPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // An error mark is always a lone, final result.
  `LPR_ASSERT_NOW(a_err_shape, clk, rst_n, out_valid && out_data.length_error, err_shape)
  // Packet heads never carry the error mark.
  `LPR_ASSERT_NOW(a_first_ok, clk, rst_n, out_valid && out_data.first_byte, pkt_err_clear)
  // Nothing leaves straight after reset.
  `LPR_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n, !out_valid)
  // The queue is empty after reset, so input is taken at once.
  `LPR_ASSERT_ALWAYS(a_rst_ready, clk, !rst_n, !in_stall)

endmodule

bind length_prefixed_packet_reassembly_core lpr_checker u_lpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lpr_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lpr_pkg::out_item_t out_data;

  // Predictor state: partial packets, fill counts and lengths per connection
  logic [lpr_pkg::BYTE_W-1:0] partial_pkt [lpr_pkg::NUM_CHANNELS][lpr_pkg::MAX_PACKET];
  logic [lpr_pkg::CNT_W-1:0]  fill_cnt [lpr_pkg::NUM_CHANNELS];
  logic [lpr_pkg::CNT_W-1:0]  pkt_len [lpr_pkg::NUM_CHANNELS];
  lpr_pkg::out_item_t         pending_bytes[$];

  logic [lpr_pkg::CH_W-1:0] last_ch = '0;
  bit              quiet = 1'b0;
  int unsigned     cycle_count = 0;
  int unsigned     mismatches = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     packets_built = 0;
  int unsigned     length_errors = 0;
  int unsigned     results_seen = 0;

  length_prefixed_packet_reassembly_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Work out what one accepted byte makes the block emit
  task automatic reassemble_byte(input logic [lpr_pkg::CH_W-1:0] ch,
                                 input logic [lpr_pkg::BYTE_W-1:0] b);
    lpr_pkg::out_item_t r;
    int unsigned        fill;
    int unsigned        len;
    fill = fill_cnt[ch];
    if (fill == 0) begin
      if (b == 0 || b > lpr_pkg::MAX_PACKET) begin
        r.out_channel  = ch;
        r.out_byte     = b;
        r.first_byte   = 1'b0;
        r.last_byte    = 1'b1;
        r.length_error = 1'b1;
        pending_bytes.push_back(r);
        length_errors++;
        return;
      end
      pkt_len[ch] = lpr_pkg::CNT_W'(b);
    end
    len = pkt_len[ch];
    // Inconsistent state: clear the connection and drop the byte
    if (len == 0 || len > lpr_pkg::MAX_PACKET || fill >= len) begin
      fill_cnt[ch] = '0;
      pkt_len[ch]  = '0;
      return;
    end
    partial_pkt[ch][fill] = b;
    fill++;
    if (fill < len) begin
      fill_cnt[ch] = lpr_pkg::CNT_W'(fill);
      return;
    end
    for (int i = 0; i < len; i++) begin
      r.out_channel  = ch;
      r.out_byte     = partial_pkt[ch][i];
      r.first_byte   = (i == 0);
      r.last_byte    = (i + 1 == len);
      r.length_error = 1'b0;
      pending_bytes.push_back(r);
    end
    fill_cnt[ch] = '0;
    pkt_len[ch]  = '0;
    packets_built++;
  endtask

  // Drive one transaction, after an optional random gap, and hold it until the block takes it
  task automatic send_byte(input logic [lpr_pkg::CH_W-1:0] ch,
                           input logic [lpr_pkg::BYTE_W-1:0] b);
    bit taken;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {ch, b};
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    reassemble_byte(ch, b);
    last_ch = ch;
    bytes_sent++;
  endtask

  // Mostly well-formed packets with random payload, some bad lengths mixed in
  task automatic send_stream_byte();
    logic [lpr_pkg::CH_W-1:0]   ch;
    logic [lpr_pkg::BYTE_W-1:0] b;
    int unsigned                pick;
    ch = ($urandom_range(0, 1) == 0) ? last_ch :
         lpr_pkg::CH_W'($urandom_range(0, lpr_pkg::NUM_CHANNELS - 1));
    if (fill_cnt[ch] != 0) begin
      b = lpr_pkg::BYTE_W'($urandom_range(0, 255));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        b = ($urandom_range(0, 1) == 0) ? 8'd0 :
            lpr_pkg::BYTE_W'($urandom_range(lpr_pkg::MAX_PACKET + 1, 255));
      else if (pick < 70)
        b = lpr_pkg::BYTE_W'($urandom_range(1, 6));
      else if (pick < 92)
        b = lpr_pkg::BYTE_W'($urandom_range(7, 20));
      else if (pick < 98)
        b = lpr_pkg::BYTE_W'($urandom_range(21, lpr_pkg::MAX_PACKET - 1));
      else
        b = lpr_pkg::BYTE_W'(lpr_pkg::MAX_PACKET);
    end
    send_byte(ch, b);
  endtask

  task automatic test_directed_cases();
    send_byte(3'd0, 8'd1);      // single-byte packet
    send_byte(3'd1, 8'd0);      // zero length
    send_byte(3'd2, 8'd65);     // just above the maximum
    send_byte(3'd3, 8'd255);
    send_byte(3'd7, 8'd2);
    send_byte(3'd7, 8'd255);
    // interleave two packets; zero and large values are payload here
    send_byte(3'd4, 8'd3);
    send_byte(3'd5, 8'd3);
    send_byte(3'd4, 8'd0);
    send_byte(3'd5, 8'd200);
    send_byte(3'd4, 8'd128);
    send_byte(3'd5, 8'd127);
    send_byte(3'd0, 8'd4);
    send_byte(3'd0, 8'h55);
    send_byte(3'd0, 8'd0);
    send_byte(3'd0, 8'hAA);
    send_byte(3'd1, 8'd66);
    send_byte(3'd1, 8'd1);
  endtask

  task automatic test_max_length_packet();
    send_byte(3'd6, lpr_pkg::BYTE_W'(lpr_pkg::MAX_PACKET));
    for (int i = 1; i < lpr_pkg::MAX_PACKET; i++) begin
      send_byte(3'd6, lpr_pkg::BYTE_W'($urandom_range(0, 255)));
      // squeeze short packets and bad lengths for other connections in between
      if (i % 8 == 0)
        send_byte(lpr_pkg::CH_W'($urandom_range(0, 5)),
                  ($urandom_range(0, 1) == 0) ? 8'd1 : 8'd0);
    end
  endtask

  task automatic test_random_interleaved(input int unsigned n);
    for (int unsigned k = 0; k < n; k++)
      send_stream_byte();
  endtask

  task automatic test_back_to_back(input int unsigned n);
    quiet = 1'b1;
    for (int unsigned k = 0; k < n; k++)
      send_stream_byte();
  endtask

  function automatic void check_field(input string name,
                                      input logic [lpr_pkg::BYTE_W-1:0] want,
                                      input logic [lpr_pkg::BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin : check_results
    lpr_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: channel %0d byte %0d", out_data.out_channel,
               out_data.out_byte);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        check_field("out_channel", lpr_pkg::BYTE_W'(want.out_channel),
                    lpr_pkg::BYTE_W'(out_data.out_channel));
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("first_byte", lpr_pkg::BYTE_W'(want.first_byte),
                    lpr_pkg::BYTE_W'(out_data.first_byte));
        check_field("last_byte", lpr_pkg::BYTE_W'(want.last_byte),
                    lpr_pkg::BYTE_W'(out_data.last_byte));
        check_field("length_error", lpr_pkg::BYTE_W'(want.length_error),
                    lpr_pkg::BYTE_W'(out_data.length_error));
      end
    end
  end

  // Receiver back-pressure in random bursts
  initial begin : drive_out_stall
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : run_tests
    for (int c = 0; c < lpr_pkg::NUM_CHANNELS; c++) begin
      fill_cnt[c] = '0;
      pkt_len[c]  = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_max_length_packet();
    test_random_interleaved(300);
    test_back_to_back(70);

    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes over %0d connections: %0d packets rebuilt, %0d bad lengths.",
             bytes_sent, lpr_pkg::NUM_CHANNELS, packets_built, length_errors);
    $display("Checked %0d results under random gaps and back-pressure.", results_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lpr_pkg.sv
hw/rtl/lpr_front.sv
hw/rtl/lpr_queue.sv
hw/rtl/lpr_back.sv
hw/rtl/length_prefixed_packet_reassembly_core.sv
hw/rtl/lpr_checker.sv
verif/tb_top.sv
